// ===== rtl/mqttd_pkg.sv =====
// shared types, constants and helpers of the mqtt packet deframer
package mqttd_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] MAX_LEN_RESET    = 8'd128;
    localparam logic [1:0] ADDR_MAX_LEN     = 2'd0;

    localparam logic [3:0] TYPE_PUB_NIBBLE  = 4'h3;
    localparam logic [7:0] TYPE_CONNACK     = 8'h20;
    localparam logic [7:0] TYPE_PUBACK      = 8'h40;
    localparam logic [7:0] TYPE_SUBACK      = 8'h90;
    localparam logic [7:0] TYPE_PINGRESP    = 8'hd0;

    localparam logic [8:0] HDR_LEN_SHORT    = 9'd2;
    localparam logic [8:0] HDR_LEN_LONG     = 9'd3;

    typedef enum logic [1:0] {
        MODE_HUNT = 2'd0,
        MODE_PASS = 2'd1,
        MODE_DROP = 2'd2
    } mode_t;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
    } res_t;

    typedef struct packed {
        logic [1:0] count;
        res_t [2:0] res;
    } rec_t;

    function automatic logic is_type_byte(input logic [7:0] b);
        return (b[7:4] == TYPE_PUB_NIBBLE) || (b == TYPE_CONNACK) ||
               (b == TYPE_PUBACK) || (b == TYPE_SUBACK) || (b == TYPE_PINGRESP);
    endfunction

endpackage

// ===== rtl/mqttd_rx_if.sv =====
// receive byte channel
interface mqttd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/mqttd_out_if.sv =====
// framed output byte channel
interface mqttd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_first;
    logic       frame_last;
    logic       run_end;

    modport source (output valid, output out_byte, output frame_first, output frame_last,
                    output run_end, input ready);
    modport sink   (input valid, input out_byte, input frame_first, input frame_last,
                    input run_end, output ready);
endinterface

// ===== rtl/mqttd_front.sv =====
// front end: header hunt, length decode and frame accept or discard per byte
module mqttd_front
    import mqttd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  max_len,
    mqttd_rx_if.sink    rx,
    input  logic        q_full,
    output logic        push,
    output rec_t        rec
);

    mode_t       mode_reg;
    mode_t       mode_next;
    logic [1:0]  hold_count_reg;
    logic [1:0]  hold_count_next;
    logic [7:0]  hold0_reg;
    logic [7:0]  hold0_next;
    logic [7:0]  hold1_reg;
    logic [7:0]  hold1_next;
    logic [7:0]  body_left_reg;
    logic [7:0]  body_left_next;
    logic [7:0]  discard_left_reg;
    logic [7:0]  discard_left_next;

    logic        fire;
    logic [7:0]  x;
    logic        pass_path;
    logic        drop_path;
    logic        hunt_path;
    logic [1:0]  hc_eff;
    logic [1:0]  hc_hunt;
    logic        settle;
    logic        hlen3;
    logic [7:0]  s_first;
    logic [7:0]  rem;
    logic [8:0]  total;
    logic        fits;

    assign rx.ready  = !q_full;
    assign fire      = rx.valid && rx.ready;
    assign x         = rx.rx_byte;
    assign pass_path = (mode_reg == MODE_PASS) && (body_left_reg != 8'd0);
    assign drop_path = (mode_reg == MODE_DROP) && (discard_left_reg != 8'd0);
    assign hunt_path = !pass_path && !drop_path;
    assign hc_eff    = (hold_count_reg == 2'd3) ? 2'd0 : hold_count_reg;

    // header hunt, including the restart after a bad second length byte
    always_comb
    begin
        hold0_next = hold0_reg;
        hold1_next = hold1_reg;
        hc_hunt    = hc_eff;
        settle     = 1'b0;
        hlen3      = 1'b0;
        s_first    = hold0_reg;
        rem        = 8'd0;
        case (hc_eff)
            2'd0:
            begin
                if (is_type_byte(x))
                begin
                    hold0_next = x;
                    hc_hunt    = 2'd1;
                end
            end
            2'd1:
            begin
                if (x[7])
                begin
                    hold1_next = x;
                    hc_hunt    = 2'd2;
                end
                else
                begin
                    settle = 1'b1;
                    rem    = {1'b0, x[6:0]};
                end
            end
            2'd2:
            begin
                if (x[7:1] != 7'd0)
                begin
                    if (is_type_byte(hold1_reg))
                    begin
                        hold0_next = hold1_reg;
                        s_first    = hold1_reg;
                        hc_hunt    = 2'd1;
                        if (x[7])
                        begin
                            hold1_next = x;
                            hc_hunt    = 2'd2;
                        end
                        else
                        begin
                            settle = 1'b1;
                            rem    = {1'b0, x[6:0]};
                        end
                    end
                    else if (is_type_byte(x))
                    begin
                        hold0_next = x;
                        hc_hunt    = 2'd1;
                    end
                    else
                    begin
                        hc_hunt = 2'd0;
                    end
                end
                else
                begin
                    settle = 1'b1;
                    hlen3  = 1'b1;
                    rem    = {x[0], hold1_reg[6:0]};
                end
            end
            default:
            begin
                hc_hunt = 2'd0;
            end
        endcase
        if (settle)
        begin
            hc_hunt = 2'd0;
        end
    end

    assign total = {1'b0, rem} + (hlen3 ? HDR_LEN_LONG : HDR_LEN_SHORT);
    assign fits  = total <= {1'b0, max_len};

    // next mode
    always_comb
    begin
        mode_next = MODE_HUNT;
        if (pass_path)
        begin
            mode_next = (body_left_reg == 8'd1) ? MODE_HUNT : MODE_PASS;
        end
        else if (drop_path)
        begin
            mode_next = (discard_left_reg == 8'd1) ? MODE_HUNT : MODE_DROP;
        end
        else if (settle && (rem != 8'd0))
        begin
            mode_next = fits ? MODE_PASS : MODE_DROP;
        end
    end

    // result words and counters
    always_comb
    begin
        rec               = '0;
        body_left_next    = body_left_reg;
        discard_left_next = discard_left_reg;
        hold_count_next   = hold_count_reg;
        if (pass_path)
        begin
            body_left_next     = body_left_reg - 8'd1;
            rec.count          = 2'd1;
            rec.res[0].data    = x;
            rec.res[0].last    = (body_left_reg == 8'd1);
        end
        else if (drop_path)
        begin
            discard_left_next = discard_left_reg - 8'd1;
        end
        else
        begin
            hold_count_next = hc_hunt;
            if (settle)
            begin
                if (fits)
                begin
                    body_left_next  = rem;
                    rec.res[0].data  = s_first;
                    rec.res[0].first = 1'b1;
                    if (hlen3)
                    begin
                        rec.count       = 2'd3;
                        rec.res[1].data = hold1_reg;
                        rec.res[2].data = x;
                        rec.res[2].last = (rem == 8'd0);
                    end
                    else
                    begin
                        rec.count       = 2'd2;
                        rec.res[1].data = x;
                        rec.res[1].last = (rem == 8'd0);
                    end
                end
                else
                begin
                    discard_left_next = rem;
                end
            end
        end
    end

    assign push = fire && (rec.count != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_HUNT;
            hold_count_reg   <= 2'd0;
            body_left_reg    <= 8'd0;
            discard_left_reg <= 8'd0;
        end
        else if (fire)
        begin
            mode_reg         <= mode_next;
            hold_count_reg   <= hold_count_next;
            body_left_reg    <= body_left_next;
            discard_left_reg <= discard_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && hunt_path)
        begin
            hold0_reg <= hold0_next;
            hold1_reg <= hold1_next;
        end
    end

    a_hold_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        hold_count_reg != 2'd3)
        else $error("hold count out of range");

    a_no_hold_in_body: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_PASS) || (mode_reg == MODE_DROP) |-> hold_count_reg == 2'd0)
        else $error("header bytes held during body");

endmodule

// ===== rtl/mqttd_queue.sv =====
// short queue of result records between front and back end
module mqttd_queue
    import mqttd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  rec_t push_rec,
    output logic full,
    input  logic pop,
    output logic valid,
    output rec_t head
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    rec_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign valid = (count_reg != '0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("queue underflow");

endmodule

// ===== rtl/mqttd_back.sv =====
// back end: sends the words of each record one per cycle while tx is ready
module mqttd_back
    import mqttd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  rec_t        head,
    output logic        pop,
    mqttd_out_if.source tx
);

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       last_res;
    logic       fire;

    assign last_res       = (idx_reg == (head.count - 2'd1));
    assign fire           = tx.valid && tx.ready;
    assign pop            = fire && last_res;

    assign tx.valid       = q_valid;
    assign tx.out_byte    = head.res[idx_reg].data;
    assign tx.frame_first = head.res[idx_reg].first;
    assign tx.frame_last  = head.res[idx_reg].last;
    assign tx.run_end     = last_res;

    always_comb
    begin
        idx_next = idx_reg;
        if (fire)
        begin
            idx_next = last_res ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    a_first_not_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        tx.valid && tx.frame_first |-> !tx.run_end)
        else $error("type byte closes its run");

endmodule

// ===== rtl/mqtt_packet_deframer.sv =====
// mqtt packet deframer top level
// Usage:
//   rx carries one received byte per word (valid/ready). Accepted frames come
//   out on tx one byte per word, with frame_first on the type byte,
//   frame_last on the byte that completes the frame and run_end on the last
//   word caused by one received byte.
//   The APB port holds max_packet_len at address 0 (reset 128); write it
//   only while the block is idle. pready is always high.
// Timing:
//   the front end takes one byte per cycle while the queue is not full and
//   writes at most one record per byte into a short queue; the back end sends
//   one word per cycle while tx is ready, the first word of a byte once its
//   record is registered in the queue. A header-settling byte gives up to
//   three words, absorbed by the queue; rx.ready falls only when the queue is
//   full. Body bytes flow at one byte per cycle while tx is ready.
// Reset:
//   rst_n clears the hunt state, counters and queue; no clearing pass.
//   When tx stalls the queue fills and rx.ready drops; nothing is lost.
module mqtt_packet_deframer
    import mqttd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    mqttd_rx_if.sink    rx,
    mqttd_out_if.source tx
);

    logic [7:0] max_len_reg;
    logic       cfg_wr;
    logic       push;
    rec_t       push_rec;
    logic       q_full;
    logic       q_valid;
    logic       pop;
    rec_t       head;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MAX_LEN) ? {24'd0, max_len_reg} : 32'd0;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_MAX_LEN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_wr)
        begin
            max_len_reg <= pwdata[7:0];
        end
    end

    mqttd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .max_len (max_len_reg),
        .rx      (rx),
        .q_full  (q_full),
        .push    (push),
        .rec     (push_rec)
    );

    mqttd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .full     (q_full),
        .pop      (pop),
        .valid    (q_valid),
        .head     (head)
    );

    mqttd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .head    (head),
        .pop     (pop),
        .tx      (tx)
    );

endmodule
